@@ src/salct_pkg.sv @@
// Shared constants of the set-associative LRU cache tag store.
`default_nettype none

package salct_pkg;

    // Default geometry, handed to the top level as parameter defaults.
    localparam int WAYS_DEF        = 4;
    localparam int SET_BITS_DEF    = 6;
    localparam int OFFSET_BITS_DEF = 4;
    localparam int ADDR_BITS_DEF   = 32;

    // Fixed field widths of the request and result items.
    localparam int ADDR_W  = 32;
    localparam int WAY_W   = 2;
    localparam int COUNT_W = 32;

    // Result layout on the master data bus, lowest bit first.
    localparam int RES_HIT_LSB  = 0;
    localparam int RES_WAY_LSB  = RES_HIT_LSB + 1;
    localparam int RES_HITC_LSB = RES_WAY_LSB + WAY_W;
    localparam int RES_MISC_LSB = RES_HITC_LSB + COUNT_W;
    localparam int RES_BITS     = RES_MISC_LSB + COUNT_W;
    localparam int RES_W        = ((RES_BITS + 7) / 8) * 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage : salct_pkg

`default_nettype wire

@@ src/salct_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module salct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read of the entry being written returns the old contents.
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule : salct_ram

`default_nettype wire

@@ src/set_assoc_lru_cache_tags.sv @@
// A request is registered in the lookup stage, then its result in the output register.
// Throughput: one request per cycle unless the output stalls; a same-set follow-on is
// served by forwarding the row written back in the previous cycle, so the set RAM never
// stalls intake. Reset: aresetn clears the counters and starts a pass that zeroes the
// set RAM, one set per cycle (2**SET_BITS sets, 64 by default) while no request is taken.
`default_nettype none

module set_assoc_lru_cache_tags #(
    parameter int WAYS        = salct_pkg::WAYS_DEF,
    parameter int SET_BITS    = salct_pkg::SET_BITS_DEF,
    parameter int OFFSET_BITS = salct_pkg::OFFSET_BITS_DEF,
    parameter int ADDR_BITS   = salct_pkg::ADDR_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    // address [31:0]
    input  wire logic [salct_pkg::ADDR_W-1:0] s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // hit [0], way [2:1], hit_count [34:3], miss_count [66:35], zero [71:67]
    output logic      [salct_pkg::RES_W-1:0]  m_axis_tdata
);

    localparam int NUM_SETS = 2 ** SET_BITS;
    localparam int EFF_A    = (ADDR_BITS >= salct_pkg::ADDR_W) ? salct_pkg::ADDR_W : ADDR_BITS;
    localparam int SO_BITS  = SET_BITS + OFFSET_BITS;
    localparam int TAG_W    = (EFF_A > SO_BITS) ? EFF_A - SO_BITS : 1;
    localparam int RANK_W   = $clog2(WAYS);
    localparam int ENTRY_W  = 1 + TAG_W + RANK_W;
    localparam int ROW_W    = WAYS * ENTRY_W;

    localparam logic [salct_pkg::ADDR_W-1:0] AMASK = (ADDR_BITS >= salct_pkg::ADDR_W) ?
        '1 : salct_pkg::ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [RANK_W-1:0] RANK_LAST = RANK_W'(WAYS - 1);

    // Request decode
    logic [salct_pkg::ADDR_W-1:0] in_addr;
    logic [salct_pkg::ADDR_W-1:0] in_tag_full;
    logic [SET_BITS-1:0]          in_set;
    logic                         in_fire;

    // Lookup stage
    logic                s1_valid_reg, s1_valid_next;
    logic [SET_BITS-1:0] s1_set_reg;
    logic [TAG_W-1:0]    s1_tag_reg;
    logic                s1_fire;
    logic                fwd_sel_reg;
    logic [ROW_W-1:0]    fwd_row_reg;
    logic [ROW_W-1:0]    ram_q;
    logic [ROW_W-1:0]    cur_row;
    logic [ROW_W-1:0]    new_row;

    // Reset clearing pass
    logic                clr_active_reg;
    logic [SET_BITS-1:0] clr_addr_reg;

    // RAM write port
    logic                ram_we;
    logic [SET_BITS-1:0] ram_waddr;
    logic [ROW_W-1:0]    ram_wdata;

    // Per-way view of the current row
    logic [WAYS-1:0]   cur_v;
    logic [TAG_W-1:0]  cur_t [WAYS];
    logic [RANK_W-1:0] cur_r [WAYS];
    logic [WAYS-1:0]   hit_vec;
    logic              hit;
    logic [RANK_W-1:0] hit_idx;
    logic [RANK_W-1:0] inv_idx;
    logic              any_inv;
    logic [RANK_W-1:0] lru_idx;
    logic [RANK_W-1:0] use_idx;
    logic [RANK_W-1:0] old_rank;
    logic [RANK_W-1:0] upd_rank;

    // Output and counters
    logic                          m_valid_reg, m_valid_next;
    logic                          m_hit_reg;
    logic [salct_pkg::WAY_W-1:0]   m_way_reg;
    logic [salct_pkg::COUNT_W-1:0] hit_cnt_reg, hit_cnt_next;
    logic [salct_pkg::COUNT_W-1:0] miss_cnt_reg, miss_cnt_next;
    logic                          out_free;

    assign in_addr     = s_axis_tdata & AMASK;
    assign in_set      = in_addr[OFFSET_BITS +: SET_BITS];
    assign in_tag_full = in_addr >> SO_BITS;

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s1_fire       = s1_valid_reg && out_free;
    assign s_axis_tready = !clr_active_reg && (!s1_valid_reg || s1_fire);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign ram_we    = clr_active_reg || s1_fire;
    assign ram_waddr = clr_active_reg ? clr_addr_reg : s1_set_reg;
    assign ram_wdata = clr_active_reg ? '0 : new_row;

    salct_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_set_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_fire),
        .raddr (in_set),
        .rdata (ram_q)
    );

    // The row read alongside a write-back of the same set is stale; take the forwarded copy.
    assign cur_row = fwd_sel_reg ? fwd_row_reg : ram_q;

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            {cur_v[w], cur_t[w], cur_r[w]} = cur_row[w*ENTRY_W +: ENTRY_W];
            hit_vec[w] = cur_v[w] && (cur_t[w] == s1_tag_reg);
        end
    end

    assign hit = |hit_vec;

    // Lowest-numbered hit, free way and oldest way. Valid ranks always form a
    // permutation, so in a full set exactly one way holds the last rank.
    always_comb begin
        hit_idx = '0;
        inv_idx = '0;
        any_inv = 1'b0;
        lru_idx = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit_idx = RANK_W'(w);
            end
            if (!cur_v[w]) begin
                inv_idx = RANK_W'(w);
                any_inv = 1'b1;
            end
            if (cur_r[w] == RANK_LAST) begin
                lru_idx = RANK_W'(w);
            end
        end
    end

    assign use_idx  = hit ? hit_idx : (any_inv ? inv_idx : lru_idx);
    assign old_rank = cur_v[use_idx] ? cur_r[use_idx] : RANK_LAST;

    always_comb begin
        new_row  = '0;
        upd_rank = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (RANK_W'(w) == use_idx) begin
                new_row[w*ENTRY_W +: ENTRY_W] = {1'b1, s1_tag_reg, {RANK_W{1'b0}}};
            end else begin
                upd_rank = cur_r[w];
                if (cur_v[w] && (cur_r[w] < old_rank)) begin
                    upd_rank = cur_r[w] + 1'b1;
                end
                new_row[w*ENTRY_W +: ENTRY_W] = {cur_v[w], cur_t[w], upd_rank};
            end
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (in_fire) begin
            s1_valid_next = 1'b1;
        end else if (s1_fire) begin
            s1_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (s1_fire) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        if (s1_fire) begin
            if (hit) begin
                if (hit_cnt_reg != salct_pkg::COUNT_MAX) begin
                    hit_cnt_next = hit_cnt_reg + 1'b1;
                end
            end else begin
                if (miss_cnt_reg != salct_pkg::COUNT_MAX) begin
                    miss_cnt_next = miss_cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            fwd_sel_reg    <= 1'b0;
            hit_cnt_reg    <= '0;
            miss_cnt_reg   <= '0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            hit_cnt_reg  <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
            if (clr_active_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == {SET_BITS{1'b1}}) begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (in_fire) begin
                fwd_sel_reg <= s1_fire && (s1_set_reg == in_set);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            s1_set_reg  <= in_set;
            s1_tag_reg  <= TAG_W'(in_tag_full);
            fwd_row_reg <= new_row;
        end
        if (s1_fire) begin
            m_hit_reg <= hit;
            m_way_reg <= salct_pkg::WAY_W'(use_idx);
        end
    end

    // Counters only move when a new result is loaded, so they hold with it.
    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[salct_pkg::RES_HIT_LSB]                          = m_hit_reg;
        m_axis_tdata[salct_pkg::RES_WAY_LSB +: salct_pkg::WAY_W]      = m_way_reg;
        m_axis_tdata[salct_pkg::RES_HITC_LSB +: salct_pkg::COUNT_W]   = hit_cnt_reg;
        m_axis_tdata[salct_pkg::RES_MISC_LSB +: salct_pkg::COUNT_W]   = miss_cnt_reg;
    end

    assign m_axis_tvalid = m_valid_reg;

endmodule : set_assoc_lru_cache_tags

`default_nettype wire
